// File: rtl/core/acpu_pkg.sv
package acpu_pkg;

    // Register file geometry
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_FIRST        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_SECOND       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_FLOOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CORRECTION  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CORRECTION = 3'd6;

    // Reset values
    localparam logic [CFG_W-1:0] RST_LEARNING_RATE     = 32'd4294967;
    localparam logic [CFG_W-1:0] RST_BETA_FIRST        = 32'd3865470566;
    localparam logic [CFG_W-1:0] RST_BETA_SECOND       = 32'd4290672329;
    localparam logic [CFG_W-1:0] RST_EPSILON_FLOOR     = 32'd1;
    localparam logic [CFG_W-1:0] RST_DECAY_RATE        = 32'd0;
    localparam logic [CFG_W-1:0] RST_FIRST_CORRECTION  = 32'd655360;
    localparam logic [CFG_W-1:0] RST_SECOND_CORRECTION = 32'd65536000;

    // Fraction bits of the bias corrections (Q16.16)
    localparam int CORR_FRAC = 16;

    typedef struct packed {
        logic [CFG_W-1:0] learning_rate;
        logic [CFG_W-1:0] beta_first;
        logic [CFG_W-1:0] beta_second;
        logic [CFG_W-1:0] epsilon_floor;
        logic [CFG_W-1:0] decay_rate;
        logic [CFG_W-1:0] first_correction;
        logic [CFG_W-1:0] second_correction;
    } t_cfg;

    // Flow control shared by the front, square root and divider sections
    typedef struct packed {
        logic valid;
        logic ce;
    } t_flow;

endpackage

// File: rtl/core/adam_clipped_param_update.sv
// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_grad_value, i_param_value,
//                                                  i_moment_one, i_moment_two
// out       output     o_out_valid / i_out_ready   o_new_param, o_new_moment_one,
//                                                  o_new_moment_two, o_update_clipped
// cfg       input      i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One coordinate enters per cycle while the skid is empty. An input transfer passes through the
// front, the square root (one root bit per stage), the denominator register, the divider
// (one quotient bit per stage), stages E1 to E3 and the output register before output valid.
// Reset is synchronous and active low; it clears valid bits and loads the registers.
// An output register plus a skid register follow the pipeline: the pipeline keeps
// moving while one result waits and stalls as a whole only when the skid is full.
module adam_clipped_param_update
    import acpu_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_grad_value,
    input  logic signed [DATA_WIDTH-1:0] i_param_value,
    input  logic signed [DATA_WIDTH-1:0] i_moment_one,
    input  logic        [DATA_WIDTH-1:0] i_moment_two,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_new_param,
    output logic signed [DATA_WIDTH-1:0] o_new_moment_one,
    output logic        [DATA_WIDTH-1:0] o_new_moment_two,
    output logic                         o_update_clipped,
    input  logic                         i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [CFG_W-1:0]      i_cfg_data
);

    localparam int W      = DATA_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int MW     = W + 16;                     // |corrected first moment|
    localparam int VHW    = W + 16;                     // corrected second moment
    localparam int RADW   = VHW + 64 - F;               // radicand, root lands in Q.32
    localparam int ROOT_W = (RADW + 1) / 2;
    localparam int DEN_W  = ((ROOT_W > CFG_W) ? ROOT_W : CFG_W) + 1;
    localparam int SQ_SW  = 3 * W + 1 + MW;
    localparam int DV_SW  = 3 * W + 1;
    localparam int DIF_W  = ((W > F + 3) ? W : F + 3) + 1;

    localparam logic [F:0]   U_MAG_ONE   = {1'b1, {F{1'b0}}};
    localparam logic [F+1:0] U_ONE       = {2'b01, {F{1'b0}}};
    localparam logic [F+1:0] U_MINUS_ONE = {2'b11, {F{1'b0}}};

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learning_rate     <= RST_LEARNING_RATE;
            r_cfg.beta_first        <= RST_BETA_FIRST;
            r_cfg.beta_second       <= RST_BETA_SECOND;
            r_cfg.epsilon_floor     <= RST_EPSILON_FLOOR;
            r_cfg.decay_rate        <= RST_DECAY_RATE;
            r_cfg.first_correction  <= RST_FIRST_CORRECTION;
            r_cfg.second_correction <= RST_SECOND_CORRECTION;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEARNING_RATE:     r_cfg.learning_rate     <= i_cfg_data;
                CFG_BETA_FIRST:        r_cfg.beta_first        <= i_cfg_data;
                CFG_BETA_SECOND:       r_cfg.beta_second       <= i_cfg_data;
                CFG_EPSILON_FLOOR:     r_cfg.epsilon_floor     <= i_cfg_data;
                CFG_DECAY_RATE:        r_cfg.decay_rate        <= i_cfg_data;
                CFG_FIRST_CORRECTION:  r_cfg.first_correction  <= i_cfg_data;
                CFG_SECOND_CORRECTION: r_cfg.second_correction <= i_cfg_data;
                default: ;  // drop writes past the last register
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Global advance: hold every stage only while the skid is occupied
    // ---------------------------------------------------------------
    logic  r_out_v;
    logic  r_skid_v;
    logic  w_ce;

    assign w_ce       = !r_skid_v;
    assign o_in_ready = w_ce;

    // ---------------------------------------------------------------
    // Front: moment blends, bias corrections, decayed parameter
    // ---------------------------------------------------------------
    logic                fr_valid;
    logic signed [W-1:0] fr_param;
    logic signed [W-1:0] fr_m1;
    logic        [W-1:0] fr_m2;
    logic       [MW-1:0] fr_mag;
    logic                fr_neg;
    logic      [VHW-1:0] fr_vhat;

    acpu_front #(
        .DATA_WIDTH (W),
        .FRAC_BITS  (F)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{valid: i_in_valid, ce: w_ce}),
        .i_grad  (i_grad_value),
        .i_param (i_param_value),
        .i_m1    (i_moment_one),
        .i_m2    (i_moment_two),
        .i_cfg   (r_cfg),
        .o_valid (fr_valid),
        .o_param (fr_param),
        .o_m1    (fr_m1),
        .o_m2    (fr_m2),
        .o_mag   (fr_mag),
        .o_neg   (fr_neg),
        .o_vhat  (fr_vhat)
    );

    // ---------------------------------------------------------------
    // Square root of the corrected second moment, scaled to Q.32
    // ---------------------------------------------------------------
    logic [2*ROOT_W-1:0] w_rad;
    logic                sq_valid;
    logic   [ROOT_W-1:0] sq_root;
    logic    [SQ_SW-1:0] sq_side;

    assign w_rad = (2*ROOT_W)'({fr_vhat, {(64-F){1'b0}}});

    acpu_sqrt #(
        .ROOT_W (ROOT_W),
        .SIDE_W (SQ_SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{valid: fr_valid, ce: w_ce}),
        .i_rad   (w_rad),
        .i_side  ({fr_param, fr_m1, fr_m2, fr_neg, fr_mag}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------------------------------------------------------
    // Denominator: root plus epsilon
    // ---------------------------------------------------------------
    logic             r_den_v;
    logic [DEN_W-1:0] r_den;
    logic  [MW-1:0]   r_den_mag;
    logic [DV_SW-1:0] r_den_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den_v <= 1'b0;
        end else if (w_ce) begin
            r_den_v <= sq_valid;
        end
        if (w_ce) begin
            r_den      <= DEN_W'(sq_root) + DEN_W'(r_cfg.epsilon_floor);
            r_den_mag  <= sq_side[MW-1:0];
            r_den_side <= sq_side[SQ_SW-1:MW];
        end
    end

    // ---------------------------------------------------------------
    // Divider: |m_hat| * 2^32 / denominator, with clip detect
    // ---------------------------------------------------------------
    logic             dv_valid;
    logic [F:0]       dv_quo;
    logic             dv_clip;
    logic             dv_zero;
    logic [DV_SW-1:0] dv_side;

    acpu_div #(
        .MAG_W     (MW),
        .DEN_W     (DEN_W),
        .FRAC_BITS (F),
        .SIDE_W    (DV_SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{valid: r_den_v, ce: w_ce}),
        .i_mag   (r_den_mag),
        .i_den   (r_den),
        .i_side  (r_den_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_clip  (dv_clip),
        .o_zero  (dv_zero),
        .o_side  (dv_side)
    );

    // Side bundle layout: {param, m1, m2, neg}
    logic signed [W-1:0] dv_param;
    logic signed [W-1:0] dv_m1;
    logic        [W-1:0] dv_m2;
    logic                dv_neg;

    assign dv_param = dv_side[3*W:2*W+1];
    assign dv_m1    = dv_side[2*W:W+1];
    assign dv_m2    = dv_side[W:1];
    assign dv_neg   = dv_side[0];

    // ---------------------------------------------------------------
    // E1: signed, clipped update
    // ---------------------------------------------------------------
    logic        [F:0]   n_e1_abs;
    logic signed [F+1:0] n_e1_u;
    logic                r_e1_v;
    logic signed [F+1:0] r_e1_u;
    logic                r_e1_clip;
    logic signed [W-1:0] r_e1_param;
    logic signed [W-1:0] r_e1_m1;
    logic        [W-1:0] r_e1_m2;

    // Clip wins; a zero numerator gives zero even over a zero denominator
    assign n_e1_abs = dv_clip ? U_MAG_ONE : (dv_zero ? '0 : dv_quo);
    assign n_e1_u   = dv_neg ? -$signed({1'b0, n_e1_abs}) : $signed({1'b0, n_e1_abs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else if (w_ce) begin
            r_e1_v <= dv_valid;
        end
        if (w_ce) begin
            r_e1_u     <= n_e1_u;
            r_e1_clip  <= dv_clip;
            r_e1_param <= dv_param;
            r_e1_m1    <= dv_m1;
            r_e1_m2    <= dv_m2;
        end
    end

    // ---------------------------------------------------------------
    // E2: scale the update by the learning rate
    // ---------------------------------------------------------------
    logic                r_e2_v;
    logic signed [F+34:0] r_e2_prod;
    logic                r_e2_clip;
    logic signed [W-1:0] r_e2_param;
    logic signed [W-1:0] r_e2_m1;
    logic        [W-1:0] r_e2_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else if (w_ce) begin
            r_e2_v <= r_e1_v;
        end
        if (w_ce) begin
            r_e2_prod  <= r_e1_u * $signed({1'b0, r_cfg.learning_rate});
            r_e2_clip  <= r_e1_clip;
            r_e2_param <= r_e1_param;
            r_e2_m1    <= r_e1_m1;
            r_e2_m2    <= r_e1_m2;
        end
    end

    // ---------------------------------------------------------------
    // E3: subtract the step from the decayed parameter, saturate
    // ---------------------------------------------------------------
    logic signed [F+2:0]   n_e3_step;
    logic signed [DIF_W-1:0] n_e3_diff;
    logic signed [W-1:0]   n_e3_param;
    logic                  r_e3_v;
    logic signed [W-1:0]   r_e3_param;
    logic signed [W-1:0]   r_e3_m1;
    logic        [W-1:0]   r_e3_m2;
    logic                  r_e3_clip;

    assign n_e3_step = (F+3)'(r_e2_prod >>> 32);
    assign n_e3_diff = $signed({{(DIF_W-W){r_e2_param[W-1]}}, r_e2_param})
                     - $signed({{(DIF_W-F-3){n_e3_step[F+2]}}, n_e3_step});

    always_comb begin
        if ((&n_e3_diff[DIF_W-1:W-1]) || !(|n_e3_diff[DIF_W-1:W-1])) begin
            n_e3_param = n_e3_diff[W-1:0];
        end else if (n_e3_diff[DIF_W-1]) begin
            n_e3_param = {1'b1, {(W-1){1'b0}}};
        end else begin
            n_e3_param = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_v <= 1'b0;
        end else if (w_ce) begin
            r_e3_v <= r_e2_v;
        end
        if (w_ce) begin
            r_e3_param <= n_e3_param;
            r_e3_m1    <= r_e2_m1;
            r_e3_m2    <= r_e2_m2;
            r_e3_clip  <= r_e2_clip;
        end
    end

    // ---------------------------------------------------------------
    // Output register and skid
    // ---------------------------------------------------------------
    logic signed [W-1:0] r_out_param;
    logic signed [W-1:0] r_out_m1;
    logic        [W-1:0] r_out_m2;
    logic                r_out_clip;
    logic signed [W-1:0] r_skid_param;
    logic signed [W-1:0] r_skid_m1;
    logic        [W-1:0] r_skid_m2;
    logic                r_skid_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_out_v && !i_out_ready) begin
            // Output held: park the next finished result in the skid
            if (w_ce && r_e3_v) begin
                r_skid_v <= 1'b1;
            end
        end else if (r_skid_v) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v <= r_e3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_v && !i_out_ready) begin
            if (w_ce && r_e3_v) begin
                r_skid_param <= r_e3_param;
                r_skid_m1    <= r_e3_m1;
                r_skid_m2    <= r_e3_m2;
                r_skid_clip  <= r_e3_clip;
            end
        end else if (r_skid_v) begin
            r_out_param <= r_skid_param;
            r_out_m1    <= r_skid_m1;
            r_out_m2    <= r_skid_m2;
            r_out_clip  <= r_skid_clip;
        end else begin
            r_out_param <= r_e3_param;
            r_out_m1    <= r_e3_m1;
            r_out_m2    <= r_e3_m2;
            r_out_clip  <= r_e3_clip;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_new_param      = r_out_param;
    assign o_new_moment_one = r_out_m1;
    assign o_new_moment_two = r_out_m2;
    assign o_update_clipped = r_out_clip;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while output is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready))
        else $error("skid filled without an output stall");

    a_clip_is_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e1_v && r_e1_clip) |->
            (r_e1_u == $signed(U_ONE) || r_e1_u == $signed(U_MINUS_ONE)))
        else $error("clipped update is not plus or minus one");

endmodule

// File: rtl/core/acpu_front.sv
module acpu_front
    import acpu_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_flow                        i_flow,
    input  logic signed [DATA_WIDTH-1:0] i_grad,
    input  logic signed [DATA_WIDTH-1:0] i_param,
    input  logic signed [DATA_WIDTH-1:0] i_m1,
    input  logic        [DATA_WIDTH-1:0] i_m2,
    input  t_cfg                         i_cfg,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_param,
    output logic signed [DATA_WIDTH-1:0] o_m1,
    output logic        [DATA_WIDTH-1:0] o_m2,
    output logic        [DATA_WIDTH+15:0] o_mag,
    output logic                         o_neg,
    output logic        [DATA_WIDTH+15:0] o_vhat
);

    localparam int W       = DATA_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int G2W_RAW = 2 * W - 1 - F;
    localparam int G2W     = (G2W_RAW < 1) ? 1 : G2W_RAW;
    localparam int DVW     = ((W > G2W) ? W : G2W) + 2;
    localparam int MW      = W + 16;

    // Stage 1: square, moment difference, decay product
    logic        [W-1:0]   n1_gabs;
    logic        [2*W-1:0] n1_gsq;
    logic signed [W:0]     n1_dm;
    logic        [63:0]    n1_ld;
    logic                  r1_valid;
    logic        [2*W-1:0] r1_gsq;
    logic signed [W:0]     r1_dm;
    logic        [63:0]    r1_ld;
    logic signed [W-1:0]   r1_g;
    logic signed [W-1:0]   r1_p;
    logic        [W-1:0]   r1_v;

    assign n1_gabs = i_grad[W-1] ? W'(-i_grad) : i_grad;
    assign n1_gsq  = (2*W)'(n1_gabs) * (2*W)'(n1_gabs);
    assign n1_dm   = $signed({i_m1[W-1], i_m1}) - $signed({i_grad[W-1], i_grad});
    assign n1_ld   = 64'(i_cfg.learning_rate) * 64'(i_cfg.decay_rate);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_flow.ce) begin
            r1_valid <= i_flow.valid;
        end
        if (i_flow.ce) begin
            r1_gsq <= n1_gsq;
            r1_dm  <= n1_dm;
            r1_ld  <= n1_ld;
            r1_g   <= i_grad;
            r1_p   <= i_param;
            r1_v   <= i_m2;
        end
    end

    // Stage 2: first moment product, second moment difference, decayed parameter product
    logic        [G2W-1:0]  n2_g2;
    logic        [32:0]     n2_f;
    logic signed [DVW-1:0]  n2_dv;
    logic signed [W+33:0]   n2_mprod;
    logic signed [W+33:0]   n2_pprod;
    logic                   r2_valid;
    logic signed [DVW-1:0]  r2_dv;
    logic signed [W+33:0]   r2_mprod;
    logic signed [W+33:0]   r2_pprod;
    logic signed [W-1:0]    r2_g;
    logic        [G2W-1:0]  r2_g2;

    assign n2_g2    = G2W'(r1_gsq >> F);
    assign n2_f     = 33'h1_0000_0000 - {1'b0, r1_ld[63:32]};
    assign n2_dv    = $signed({{(DVW-W){1'b0}}, r1_v}) - $signed({{(DVW-G2W){1'b0}}, n2_g2});
    assign n2_mprod = r1_dm * $signed({1'b0, i_cfg.beta_first});
    assign n2_pprod = r1_p * $signed({1'b0, n2_f});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_flow.ce) begin
            r2_valid <= r1_valid;
        end
        if (i_flow.ce) begin
            r2_dv    <= n2_dv;
            r2_mprod <= n2_mprod;
            r2_pprod <= n2_pprod;
            r2_g     <= r1_g;
            r2_g2    <= n2_g2;
        end
    end

    // Stage 3: first moment sum and saturate, second moment product
    logic signed [W+1:0]    n3_msum;
    logic signed [W-1:0]    n3_m1;
    logic signed [DVW+32:0] n3_vprod;
    logic signed [W-1:0]    n3_pdec;
    logic                   r3_valid;
    logic signed [DVW+32:0] r3_vprod;
    logic signed [W-1:0]    r3_m1;
    logic        [G2W-1:0]  r3_g2;
    logic signed [W-1:0]    r3_pdec;

    assign n3_msum  = $signed({{2{r2_g[W-1]}}, r2_g}) + $signed((W+2)'(r2_mprod >>> 32));
    assign n3_vprod = r2_dv * $signed({1'b0, i_cfg.beta_second});
    assign n3_pdec  = W'(r2_pprod >>> 32);

    always_comb begin
        if ((&n3_msum[W+1:W-1]) || !(|n3_msum[W+1:W-1])) begin
            n3_m1 = n3_msum[W-1:0];
        end else if (n3_msum[W+1]) begin
            n3_m1 = {1'b1, {(W-1){1'b0}}};
        end else begin
            n3_m1 = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_flow.ce) begin
            r3_valid <= r2_valid;
        end
        if (i_flow.ce) begin
            r3_vprod <= n3_vprod;
            r3_m1    <= n3_m1;
            r3_g2    <= r2_g2;
            r3_pdec  <= n3_pdec;
        end
    end

    // Stage 4: second moment sum and saturate, first correction product
    logic signed [DVW:0]   n4_vsum;
    logic        [W-1:0]   n4_m2;
    logic signed [W+32:0]  n4_mcprod;
    logic                  r4_valid;
    logic        [W-1:0]   r4_m2;
    logic signed [W+32:0]  r4_mcprod;
    logic signed [W-1:0]   r4_m1;
    logic signed [W-1:0]   r4_pdec;

    assign n4_vsum   = $signed({{(DVW+1-G2W){1'b0}}, r3_g2})
                     + $signed((DVW+1)'(r3_vprod >>> 32));
    assign n4_mcprod = r3_m1 * $signed({1'b0, i_cfg.first_correction});

    always_comb begin
        if (n4_vsum[DVW]) begin
            n4_m2 = '0;
        end else if (|n4_vsum[DVW-1:W]) begin
            n4_m2 = '1;
        end else begin
            n4_m2 = n4_vsum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_flow.ce) begin
            r4_valid <= r3_valid;
        end
        if (i_flow.ce) begin
            r4_m2     <= n4_m2;
            r4_mcprod <= n4_mcprod;
            r4_m1     <= r3_m1;
            r4_pdec   <= r3_pdec;
        end
    end

    // Stage 5: second correction product, corrected first moment magnitude
    logic        [W+31:0] n5_vcprod;
    logic signed [W+16:0] n5_mhat;
    logic        [MW-1:0] n5_mag;
    logic                 r5_valid;
    logic        [W+31:0] r5_vcprod;
    logic        [MW-1:0] r5_mag;
    logic                 r5_neg;
    logic signed [W-1:0]  r5_m1;
    logic        [W-1:0]  r5_m2;
    logic signed [W-1:0]  r5_pdec;

    assign n5_vcprod = (W+32)'(r4_m2) * (W+32)'(i_cfg.second_correction);
    assign n5_mhat   = (W+17)'(r4_mcprod >>> CORR_FRAC);
    assign n5_mag    = n5_mhat[W+16] ? MW'(-n5_mhat) : MW'(n5_mhat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_flow.ce) begin
            r5_valid <= r4_valid;
        end
        if (i_flow.ce) begin
            r5_vcprod <= n5_vcprod;
            r5_mag    <= n5_mag;
            r5_neg    <= n5_mhat[W+16];
            r5_m1     <= r4_m1;
            r5_m2     <= r4_m2;
            r5_pdec   <= r4_pdec;
        end
    end

    assign o_valid = r5_valid;
    assign o_param = r5_pdec;
    assign o_m1    = r5_m1;
    assign o_m2    = r5_m2;
    assign o_mag   = r5_mag;
    assign o_neg   = r5_neg;
    assign o_vhat  = (W+16)'(r5_vcprod >> CORR_FRAC);

endmodule

// File: rtl/core/acpu_sqrt.sv
module acpu_sqrt
    import acpu_pkg::*;
#(
    parameter int ROOT_W = 44,
    parameter int SIDE_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_flow                 i_flow,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              r_valid [1:ROOT_W];
    logic [REM_W-1:0]  r_rem   [1:ROOT_W];
    logic [ROOT_W-1:0] r_root  [1:ROOT_W];
    logic [RAD_W-1:0]  r_rad   [1:ROOT_W];
    logic [SIDE_W-1:0] r_side  [1:ROOT_W];

    // One result bit per stage, radicand consumed two bits at a time
    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic              s_valid;
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [RAD_W-1:0]  s_rad;
        logic [SIDE_W-1:0] s_side;
        logic [REM_W+1:0]  n_acc;
        logic [REM_W+1:0]  n_trial;
        logic              n_take;

        if (k == 0) begin : g_first
            assign s_valid = i_flow.valid;
            assign s_rem   = '0;
            assign s_root  = '0;
            assign s_rad   = i_rad;
            assign s_side  = i_side;
        end else begin : g_next
            assign s_valid = r_valid[k];
            assign s_rem   = r_rem[k];
            assign s_root  = r_root[k];
            assign s_rad   = r_rad[k];
            assign s_side  = r_side[k];
        end

        assign n_acc   = {s_rem, s_rad[RAD_W-1 -: 2]};
        assign n_trial = (REM_W+2)'({s_root, 2'b01});
        assign n_take  = (n_acc >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_flow.ce) begin
                r_valid[k+1] <= s_valid;
            end
            if (i_flow.ce) begin
                r_rem[k+1]  <= n_take ? REM_W'(n_acc - n_trial) : REM_W'(n_acc);
                r_root[k+1] <= {s_root[ROOT_W-2:0], n_take};
                r_rad[k+1]  <= s_rad << 2;
                r_side[k+1] <= s_side;
            end
        end
    end

    assign o_valid = r_valid[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_side  = r_side[ROOT_W];

endmodule

// File: rtl/core/acpu_div.sv
module acpu_div
    import acpu_pkg::*;
#(
    parameter int MAG_W     = 48,
    parameter int DEN_W     = 45,
    parameter int FRAC_BITS = 24,
    parameter int SIDE_W    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_flow                i_flow,
    input  logic [MAG_W-1:0]     i_mag,
    input  logic [DEN_W-1:0]     i_den,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_quo,
    output logic                 o_clip,
    output logic                 o_zero,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int F      = FRAC_BITS;
    localparam int NUM_W  = MAG_W + 32;
    localparam int CMP_A  = DEN_W + F + 1;
    localparam int CMP_W  = (NUM_W > CMP_A) ? NUM_W : CMP_A;
    localparam int STEPS  = F + 1;

    // Prep: clip test, top of the numerator as first remainder
    logic [CMP_W-1:0] n_num;
    logic [CMP_W-1:0] n_den;

    assign n_num = CMP_W'({i_mag, 32'd0});
    assign n_den = CMP_W'({i_den, {F{1'b0}}});

    logic              r_valid [0:STEPS];
    logic              r_clip  [0:STEPS];
    logic              r_zero  [0:STEPS];
    logic [DEN_W-1:0]  r_rem   [0:STEPS];
    logic [F:0]        r_low   [0:STEPS];
    logic [DEN_W-1:0]  r_den   [0:STEPS];
    logic [F:0]        r_quo   [1:STEPS];
    logic [SIDE_W-1:0] r_side  [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_flow.ce) begin
            r_valid[0] <= i_flow.valid;
        end
        if (i_flow.ce) begin
            r_clip[0] <= (n_num > n_den);
            r_zero[0] <= (i_mag == '0);
            r_rem[0]  <= n_num[F+1 +: DEN_W];
            r_low[0]  <= n_num[F:0];
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    // One quotient bit per stage, restoring
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [F:0]       s_quo;
        logic [DEN_W:0]   n_acc;
        logic             n_take;

        if (k == 0) begin : g_first
            assign s_quo = '0;
        end else begin : g_next
            assign s_quo = r_quo[k];
        end

        assign n_acc  = {r_rem[k], r_low[k][F]};
        assign n_take = (n_acc >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_flow.ce) begin
                r_valid[k+1] <= r_valid[k];
            end
            if (i_flow.ce) begin
                r_rem[k+1]  <= n_take ? DEN_W'(n_acc - {1'b0, r_den[k]}) : DEN_W'(n_acc);
                r_low[k+1]  <= r_low[k] << 1;
                r_den[k+1]  <= r_den[k];
                r_quo[k+1]  <= {s_quo[F-1:0], n_take};
                r_clip[k+1] <= r_clip[k];
                r_zero[k+1] <= r_zero[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_valid[STEPS];
    assign o_quo   = r_quo[STEPS];
    assign o_clip  = r_clip[STEPS];
    assign o_zero  = r_zero[STEPS];
    assign o_side  = r_side[STEPS];

    // An unclipped quotient never exceeds one
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_clip && !o_zero) |-> (o_quo <= {1'b1, {F{1'b0}}}))
        else $error("quotient above one without clip");

endmodule
